@@ hw/rtl/ufwj_pkg.sv @@
// Package for the union-find wall join core: grid size, field widths,
// command and direction codes and the sequencer state type. No dependencies.
package ufwj_pkg;

   // Room grid
   localparam int ROOM_ROWS  = 32;
   localparam int ROOM_COLS  = 32;
   localparam int ROOM_COUNT = ROOM_ROWS * ROOM_COLS;

   // Room index width, sized to the parent table depth
   localparam int IDX_W = $clog2(ROOM_COUNT);

   // Field widths of the request and response items
   localparam int ROW_W  = 5;
   localparam int COL_W  = 5;
   localparam int WALL_W = 7;

   // Command codes
   localparam logic CMD_JOIN  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // Direction codes
   localparam logic DIR_DOWN  = 1'b0;
   localparam logic DIR_RIGHT = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIND,
      ST_COMP,
      ST_FIND_END,
      ST_DONE
   } state_type;

endpackage

@@ hw/rtl/ufwj_req_if.sv @@
// Request channel of the union-find wall join core: valid/ready plus the
// join or clear item. Depends on ufwj_pkg.
interface ufwj_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [ufwj_pkg::ROW_W-1:0]    room_row;
   logic [ufwj_pkg::COL_W-1:0]    room_col;
   logic                          toward;

   modport source (output valid, command, room_row, room_col, toward, input ready);
   modport sink   (input valid, command, room_row, room_col, toward, output ready);
endinterface

@@ hw/rtl/ufwj_rsp_if.sv @@
// Response channel of the union-find wall join core: valid/ready plus the
// join outcome and wall cell. Depends on ufwj_pkg.
interface ufwj_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          joined;
   logic                          invalid;
   logic [ufwj_pkg::WALL_W-1:0]   wall_row;
   logic [ufwj_pkg::WALL_W-1:0]   wall_col;

   modport source (output valid, joined, invalid, wall_row, wall_col, input ready);
   modport sink   (input valid, joined, invalid, wall_row, wall_col, output ready);
endinterface

@@ hw/rtl/union_find_wall_join_core.sv @@
// Union-find core for maze generation: parent table memory plus the find,
// compress and link sequencer. Depends on ufwj_pkg, ufwj_req_if, ufwj_rsp_if.
//
// Usage:
//   req_ch carries one item per transfer: a join (room, direction) or a clear.
//   rsp_ch returns exactly one result per request, in order.
//   One item is in work at a time; req_ch.ready is high only when idle.
//   Each chain step of a find is one read of the single-read-port parent
//   memory; compression rewalks the chain with one read and one write per
//   cycle. Out-of-grid items go straight to the done state without touching
//   the table.
//   Clear: the table is rewritten one entry per cycle; the result is sent
//   once the clearing pass ends.
//   Reset runs the same clearing pass; req_ch.ready stays low until it ends,
//   and no result is sent for it.
//   A finished result sits in an output register; if rsp_ch stalls, the
//   next result waits in the done state and no new request is taken.
module union_find_wall_join_core (
   input  logic       clock,
   input  logic       reset,
   ufwj_req_if.sink   req_ch,
   ufwj_rsp_if.source rsp_ch
);

   localparam int IDX_W  = ufwj_pkg::IDX_W;
   localparam int WALL_W = ufwj_pkg::WALL_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ufwj_pkg::ROOM_COUNT - 1);

   // Parent table
   logic [IDX_W-1:0] parent_mem [ufwj_pkg::ROOM_COUNT];
   logic [IDX_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] wr_data;

   // Sequencer state
   ufwj_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  start_ff, start_in;
   logic [IDX_W-1:0]  root_ff, root_in;
   logic [IDX_W-1:0]  ra_ff, ra_in;
   logic [IDX_W-1:0]  second_ff, second_in;
   logic              which_ff, which_in;
   logic [IDX_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic              clr_reply_ff, clr_reply_in;

   // Pending result
   logic              res_joined_ff, res_joined_in;
   logic              res_invalid_ff, res_invalid_in;
   logic [WALL_W-1:0] res_wrow_ff, res_wrow_in;
   logic [WALL_W-1:0] res_wcol_ff, res_wcol_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_joined_ff, rsp_joined_in;
   logic              rsp_invalid_ff, rsp_invalid_in;
   logic [WALL_W-1:0] rsp_wrow_ff, rsp_wrow_in;
   logic [WALL_W-1:0] rsp_wcol_ff, rsp_wcol_in;

   // Request decode
   logic [ufwj_pkg::ROW_W:0] nrow;
   logic [ufwj_pkg::COL_W:0] ncol;
   logic                     off_grid;
   logic [IDX_W-1:0]         first_idx;
   logic [IDX_W-1:0]         second_idx;
   logic [WALL_W-1:0]        wall_row;
   logic [WALL_W-1:0]        wall_col;
   logic                     req_xfer;

   assign req_xfer = req_ch.valid && req_ch.ready;

   // Neighbour room, grid check, indexes and wall cell
   always_comb begin
      nrow = {1'b0, req_ch.room_row} +
             (ufwj_pkg::ROW_W + 1)'(req_ch.toward == ufwj_pkg::DIR_DOWN);
      ncol = {1'b0, req_ch.room_col} +
             (ufwj_pkg::COL_W + 1)'(req_ch.toward == ufwj_pkg::DIR_RIGHT);
      off_grid = (int'(req_ch.room_row) >= ufwj_pkg::ROOM_ROWS) ||
                 (int'(req_ch.room_col) >= ufwj_pkg::ROOM_COLS) ||
                 (int'(nrow) >= ufwj_pkg::ROOM_ROWS) ||
                 (int'(ncol) >= ufwj_pkg::ROOM_COLS);
      first_idx  = IDX_W'(int'(req_ch.room_row) * ufwj_pkg::ROOM_COLS +
                          int'(req_ch.room_col));
      second_idx = IDX_W'(int'(nrow) * ufwj_pkg::ROOM_COLS + int'(ncol));
      wall_row = WALL_W'(req_ch.room_row) + WALL_W'(nrow) + WALL_W'(1);
      wall_col = WALL_W'(req_ch.room_col) + WALL_W'(ncol) + WALL_W'(1);
   end

   // Parent memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         parent_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= parent_mem[rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ufwj_pkg::ST_CLEAR;
         which_ff     <= 1'b0;
         clr_cnt_ff   <= '0;
         clr_reply_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         which_ff     <= which_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_reply_ff <= clr_reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      start_ff       <= start_in;
      root_ff        <= root_in;
      ra_ff          <= ra_in;
      second_ff      <= second_in;
      res_joined_ff  <= res_joined_in;
      res_invalid_ff <= res_invalid_in;
      res_wrow_ff    <= res_wrow_in;
      res_wcol_ff    <= res_wcol_in;
      rsp_joined_ff  <= rsp_joined_in;
      rsp_invalid_ff <= rsp_invalid_in;
      rsp_wrow_ff    <= rsp_wrow_in;
      rsp_wcol_ff    <= rsp_wcol_in;
   end

   // Next state, memory access and result
   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      start_in       = start_ff;
      root_in        = root_ff;
      ra_in          = ra_ff;
      second_in      = second_ff;
      which_in       = which_ff;
      clr_cnt_in     = clr_cnt_ff;
      clr_reply_in   = clr_reply_ff;
      res_joined_in  = res_joined_ff;
      res_invalid_in = res_invalid_ff;
      res_wrow_in    = res_wrow_ff;
      res_wcol_in    = res_wcol_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_joined_in  = rsp_joined_ff;
      rsp_invalid_in = rsp_invalid_ff;
      rsp_wrow_in    = rsp_wrow_ff;
      rsp_wcol_in    = rsp_wcol_ff;
      rd_addr        = cur_ff;
      wr_en          = 1'b0;
      wr_addr        = cur_ff;
      wr_data        = root_ff;

      unique case (state_ff)
         // Sweep every entry back to its own index
         ufwj_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
            wr_data = clr_cnt_ff;
            if (clr_cnt_ff == LAST_IDX) begin
               clr_cnt_in = '0;
               state_in   = clr_reply_ff ? ufwj_pkg::ST_DONE : ufwj_pkg::ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + IDX_W'(1);
            end
         end

         // Take a request: start a clear, finish an off-grid join, or start the first find
         ufwj_pkg::ST_IDLE: begin
            rd_addr = first_idx;
            if (req_xfer) begin
               res_joined_in  = 1'b0;
               res_invalid_in = 1'b0;
               res_wrow_in    = '0;
               res_wcol_in    = '0;
               if (req_ch.command == ufwj_pkg::CMD_CLEAR) begin
                  clr_cnt_in   = '0;
                  clr_reply_in = 1'b1;
                  state_in     = ufwj_pkg::ST_CLEAR;
               end else if (off_grid) begin
                  res_invalid_in = 1'b1;
                  state_in       = ufwj_pkg::ST_DONE;
               end else begin
                  start_in    = first_idx;
                  cur_in      = first_idx;
                  second_in   = second_idx;
                  which_in    = 1'b0;
                  res_wrow_in = wall_row;
                  res_wcol_in = wall_col;
                  state_in    = ufwj_pkg::ST_FIND;
               end
            end
         end

         // Walk parent links, one read per cycle
         ufwj_pkg::ST_FIND: begin
            if (rd_data_ff == cur_ff) begin
               root_in = cur_ff;
               if (start_ff == cur_ff) begin
                  state_in = ufwj_pkg::ST_FIND_END;
               end else begin
                  cur_in   = start_ff;
                  rd_addr  = start_ff;
                  state_in = ufwj_pkg::ST_COMP;
               end
            end else begin
               cur_in  = rd_data_ff;
               rd_addr = rd_data_ff;
            end
         end

         // Rewalk the path, pointing each node at the root
         ufwj_pkg::ST_COMP: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = root_ff;
            if (rd_data_ff == root_ff) begin
               state_in = ufwj_pkg::ST_FIND_END;
            end else begin
               cur_in  = rd_data_ff;
               rd_addr = rd_data_ff;
            end
         end

         // After first find start the second; after second, link roots
         ufwj_pkg::ST_FIND_END: begin
            if (!which_ff) begin
               ra_in    = root_ff;
               which_in = 1'b1;
               start_in = second_ff;
               cur_in   = second_ff;
               rd_addr  = second_ff;
               state_in = ufwj_pkg::ST_FIND;
            end else begin
               if (ra_ff != root_ff) begin
                  wr_en         = 1'b1;
                  wr_addr       = ra_ff;
                  wr_data       = root_ff;
                  res_joined_in = 1'b1;
               end
               state_in = ufwj_pkg::ST_DONE;
            end
         end

         // Move the result into the output register once it is free
         ufwj_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_joined_in  = res_joined_ff;
               rsp_invalid_in = res_invalid_ff;
               rsp_wrow_in    = res_wrow_ff;
               rsp_wcol_in    = res_wcol_ff;
               clr_reply_in   = 1'b0;
               state_in       = ufwj_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ufwj_pkg::ST_IDLE;
         end
      endcase
   end

   // Channel outputs
   assign req_ch.ready    = (state_ff == ufwj_pkg::ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.joined   = rsp_joined_ff;
   assign rsp_ch.invalid  = rsp_invalid_ff;
   assign rsp_ch.wall_row = rsp_wrow_ff;
   assign rsp_ch.wall_col = rsp_wcol_ff;

endmodule

@@ hw/rtl/ufwj_checker.sv @@
// Port-level checks for union_find_wall_join_core, attached by bind.
// Depends on ufwj_pkg for field widths.
module ufwj_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_joined,
   input logic                        rsp_invalid,
   input logic [ufwj_pkg::WALL_W-1:0] rsp_wall_row,
   input logic [ufwj_pkg::WALL_W-1:0] rsp_wall_col
);

   logic [1:0] pending_ff, pending_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // Requests taken but not yet answered
   always_comb begin
      pending_in = pending_ff + 2'(req_xfer) - 2'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // Clearing pass follows reset, so no request is taken right after it
   a_reset_clears: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // A result only ever answers an open request
   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result without open request");

   // At most one item in work beside the one held in the output register
   a_one_open: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> pending_ff < 2'd2)
      else $error("request taken while two are open");

   // Off-grid results carry no join and no wall
   a_invalid_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> !rsp_joined && rsp_wall_row == '0 &&
      rsp_wall_col == '0)
      else $error("invalid result with join or wall set");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_joined) &&
      $stable(rsp_invalid) && $stable(rsp_wall_row) && $stable(rsp_wall_col))
      else $error("stalled result changed");

endmodule

bind union_find_wall_join_core ufwj_checker u_ufwj_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_joined   (rsp_ch.joined),
   .rsp_invalid  (rsp_ch.invalid),
   .rsp_wall_row (rsp_ch.wall_row),
   .rsp_wall_col (rsp_ch.wall_col)
);
